/* rtl/wlgm_pkg.sv */
// ----------------------------------------------------------------------------
// wlgm_pkg: shared types and constants of the window/level gray mapper
// Pixel and quotient widths, register indexes and the divider stage payload.
// ----------------------------------------------------------------------------
package wlgm_pkg;

  localparam int PIXEL_BITS   = 16;              // active pixel bits, 8..16
  localparam int PIX_PORT_W   = 16;              // raw pixel and window port width
  localparam int QUOT_BITS    = 8;               // gray level width
  localparam int NUM_W        = PIXEL_BITS + QUOT_BITS;
  localparam int FRONT_STAGES = 2;
  localparam int PIPE_LAT     = FRONT_STAGES + QUOT_BITS + 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [QUOT_BITS-1:0] GRAY_MAX = {QUOT_BITS{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LOW  = 2'd0,
    REG_WINDOW_HIGH = 2'd1
  } cfg_reg_e;

  // Payload of one divider stage; valid travels beside it.
  typedef struct packed {
    logic                  frame_end;
    logic                  force_en;   // result is force_val, not the quotient
    logic [QUOT_BITS-1:0]  force_val;
    logic [PIXEL_BITS-1:0] rem;        // partial remainder, always below span
    logic [QUOT_BITS-1:0]  num_lo;     // numerator bits still to shift in, MSB first
    logic [PIXEL_BITS-1:0] span;
    logic [QUOT_BITS-1:0]  quot;
  } div_data_t;

endpackage

/* rtl/wlgm_front.sv */
// ----------------------------------------------------------------------------
// wlgm_front: window compare and numerator build
// Two register stages: compare against the window, then form 255*(pix-low).
// ----------------------------------------------------------------------------
module wlgm_front import wlgm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [PIXEL_BITS-1:0] pix_i,
  input  logic                  frame_end_i,
  input  logic [PIXEL_BITS-1:0] low_i,
  input  logic [PIXEL_BITS-1:0] high_i,
  output logic                  vld_o,
  output div_data_t             data_o
);

  logic                  s1_vld_q;
  logic                  s1_fe_q;
  logic                  s1_gt_q;
  logic                  s1_lt_q;
  logic [PIXEL_BITS-1:0] s1_diff_q;
  logic [PIXEL_BITS-1:0] s1_span_q;

  logic                  s2_vld_q;
  div_data_t             s2_data_q;
  div_data_t             s2_data_d;
  logic [NUM_W-1:0]      num;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_fe_q   <= frame_end_i;
    s1_gt_q   <= pix_i > high_i;
    s1_lt_q   <= pix_i < low_i;
    s1_diff_q <= pix_i - low_i;
    s1_span_q <= high_i - low_i;
  end

  // 255 * diff as (diff << 8) - diff
  assign num = {s1_diff_q, {QUOT_BITS{1'b0}}} - {{QUOT_BITS{1'b0}}, s1_diff_q};

  always_comb begin
    s2_data_d.frame_end = s1_fe_q;
    // an empty window leaves only pix == low == high, which maps to black
    s2_data_d.force_en  = s1_gt_q || s1_lt_q || (s1_span_q == '0);
    s2_data_d.force_val = s1_gt_q ? GRAY_MAX : '0;
    s2_data_d.rem       = num[NUM_W-1:QUOT_BITS];
    s2_data_d.num_lo    = num[QUOT_BITS-1:0];
    s2_data_d.span      = s1_span_q;
    s2_data_d.quot      = '0;
  end

  always_ff @(posedge clk_i) begin
    s2_data_q <= s2_data_d;
  end

  assign vld_o  = s2_vld_q;
  assign data_o = s2_data_q;

endmodule

/* rtl/wlgm_div_step.sv */
// ----------------------------------------------------------------------------
// wlgm_div_step: one restoring division stage
// Shifts in one numerator bit, subtracts the span if it fits, adds a quotient bit.
// ----------------------------------------------------------------------------
module wlgm_div_step import wlgm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  div_data_t data_i,
  output logic      vld_o,
  output div_data_t data_o
);

  logic                vld_q;
  div_data_t           data_q;
  div_data_t           data_d;
  logic [PIXEL_BITS:0] trial;
  logic                fits;

  assign trial = {data_i.rem, data_i.num_lo[QUOT_BITS-1]};
  assign fits  = trial >= {1'b0, data_i.span};

  always_comb begin
    data_d        = data_i;
    data_d.num_lo = {data_i.num_lo[QUOT_BITS-2:0], 1'b0};
    data_d.quot   = {data_i.quot[QUOT_BITS-2:0], fits};
    // remainder stays below span, so the top bit drops out
    if (fits) begin
      data_d.rem = PIXEL_BITS'(trial - {1'b0, data_i.span});
    end else begin
      data_d.rem = trial[PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

/* rtl/window_level_gray_map.sv */
// ----------------------------------------------------------------------------
// window_level_gray_map: raw detector pixel to 8-bit display gray level
// Window/level mapping, floor(255*(pix-low)/(high-low)), fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive raw_pixel_i and frame_end_i with start high; a pixel transfers
//   at every rising edge where start is high and busy is low. busy stays low:
//   the pipeline takes one pixel per clock, back to back.
//   Output: result_valid_o is high for exactly one cycle per pixel, with
//   gray_level_o and frame_end_out_o; results come in input order.
//   Pipeline: 2 compare/numerator stages, 8 divider stages of one quotient
//   bit each, 1 output register. Throughput: one pixel per cycle, set by
//   the divider being unrolled into one stage per quotient bit.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (0 window low, 1 window high); other indexes are ignored. Write only
//   while no pixel is in flight.
//   Reset: the pipeline empties at once, window resets to 0..65535.
//   The receiver cannot stall; each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module window_level_gray_map import wlgm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIX_PORT_W-1:0] raw_pixel_i,
  input  logic                  frame_end_i,
  output logic                  result_valid_o,
  output logic [QUOT_BITS-1:0]  gray_level_o,
  output logic                  frame_end_out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [PIX_PORT_W-1:0] window_low_q;
  logic [PIX_PORT_W-1:0] window_high_q;

  logic                  stg_vld  [QUOT_BITS+1];
  div_data_t             stg_data [QUOT_BITS+1];

  logic                  res_vld_q;
  logic [QUOT_BITS-1:0]  gray_q;
  logic [QUOT_BITS-1:0]  gray_d;
  logic                  fe_q;

  // no backpressure anywhere in the pipeline
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_low_q  <= '0;
      window_high_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_LOW:  window_low_q  <= cfg_wdata_i[PIX_PORT_W-1:0];
        REG_WINDOW_HIGH: window_high_q <= cfg_wdata_i[PIX_PORT_W-1:0];
        default: ;
      endcase
    end
  end

  wlgm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (start && !busy),
    .pix_i       (raw_pixel_i[PIXEL_BITS-1:0]),
    .frame_end_i (frame_end_i),
    .low_i       (window_low_q[PIXEL_BITS-1:0]),
    .high_i      (window_high_q[PIXEL_BITS-1:0]),
    .vld_o       (stg_vld[0]),
    .data_o      (stg_data[0])
  );

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_div
    wlgm_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (stg_vld[i]),
      .data_i (stg_data[i]),
      .vld_o  (stg_vld[i+1]),
      .data_o (stg_data[i+1])
    );
  end

  assign gray_d = stg_data[QUOT_BITS].force_en ? stg_data[QUOT_BITS].force_val
                                               : stg_data[QUOT_BITS].quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= stg_vld[QUOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    gray_q <= gray_d;
    fe_q   <= stg_data[QUOT_BITS].frame_end;
  end

  assign result_valid_o  = res_vld_q;
  assign gray_level_o    = gray_q;
  assign frame_end_out_o = fe_q;

  // every transfer yields a result after the fixed latency, and nothing else does
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##PIPE_LAT result_valid_o)
    else $error("transferred pixel produced no result");

  a_lat_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, PIPE_LAT))
    else $error("result without a transferred pixel");

  a_fe_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> frame_end_out_o == $past(frame_end_i, PIPE_LAT))
    else $error("frame end mark out of step with its pixel");

  a_above_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(start && (raw_pixel_i[PIXEL_BITS-1:0] >
      window_high_q[PIXEL_BITS-1:0]), PIPE_LAT) |-> gray_level_o == GRAY_MAX)
    else $error("pixel above window not mapped to white");

endmodule
